### hdl/ihop_pkg.sv
`timescale 1ns / 1ps

package ihop_pkg;

  // Fixed part of the IPv4 header, in bytes.
  localparam int unsigned FIXED_HDR_BYTES = 20;
  // Smallest legal length byte of a multi-byte option (type and length bytes).
  localparam logic [7:0] OPT_MIN_LEN = 8'd2;

  typedef enum logic [1:0] {
    KIND_OPTION    = 2'd0,
    KIND_SUMMARY   = 2'd1,
    KIND_MALFORMED = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } opt_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  option_type;
    logic [5:0]  option_data_offset;
    logic [5:0]  option_data_length;
    logic [5:0]  header_bytes;
    logic [7:0]  protocol;
    logic        fragmented;
    logic [15:0] payload_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  time_to_live;
    logic [15:0] identification;
  } out_beat_t;

  // One queue entry: what a single accepted byte leaves for the back end.
  typedef struct packed {
    logic        opt_valid;
    logic [7:0]  opt_code;
    logic [5:0]  opt_off;
    logic [5:0]  opt_len;
    logic        fin_valid;
    logic        fin_bad;
    logic [5:0]  header_bytes;
    logic [7:0]  protocol;
    logic        fragmented;
    logic [15:0] total_length;
    logic [15:0] bytes_received;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  time_to_live;
    logic [15:0] identification;
  } q_entry_t;

endpackage

### hdl/ihop_front.sv
`timescale 1ns / 1ps

module ihop_front
  import ihop_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     beat_ok,
  input  in_beat_t beat,
  output logic     push,
  output q_entry_t entry
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_FIX = POS_W'(FIXED_HDR_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  opt_phase_t       phase_r, phase_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [5:0]       left_r, left_nxt;
  logic             done_r, done_nxt;
  logic             bad_r, bad_nxt;

  logic [7:0] hdr_r [FIXED_HDR_BYTES];
  logic [7:0] hdr_v [FIXED_HDR_BYTES];

  logic [7:0]  b;
  logic [5:0]  hlen;
  logic [5:0]  p6;
  logic        in_opts;
  logic        at_end;
  logic        multi;
  logic        is_end;
  logic        len_bad;
  logic [5:0]  dlen;
  logic [5:0]  left_dec;
  logic        opt_emit;
  logic        fin_bad;

  assign b = beat.data_byte;

  // Header view including the byte on the input this cycle.
  always_comb begin
    for (int i = 0; i < FIXED_HDR_BYTES; i++) begin
      hdr_v[i] = (pos_r == POS_W'(i)) ? b : hdr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIXED_HDR_BYTES; i++) begin
      if (beat_ok && pos_r == POS_W'(i)) begin
        hdr_r[i] <= b;
      end
    end
  end

  assign hlen    = {hdr_v[0][3:0], 2'b00};
  assign p6      = pos_r[5:0];
  assign in_opts = (pos_r >= POS_FIX) && (pos_r < POS_W'(hlen)) && !done_r;
  assign at_end  = (p6 + 6'd1) == hlen;
  assign multi   = b[4:0] > 5'd1;
  assign is_end  = b == 8'd0;
  assign len_bad = (b < OPT_MIN_LEN)
                 || (({4'b0, p6} + {2'b0, b} - 10'd1) > {4'b0, hlen});
  assign dlen    = 6'(b - OPT_MIN_LEN);
  assign left_dec = (left_r != 6'd0) ? left_r - 6'd1 : left_r;

  // Next state of the option walker.
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    left_nxt  = left_r;
    done_nxt  = done_r;
    bad_nxt   = bad_r;
    if (in_opts) begin
      case (phase_r)
        PH_TYPE: begin
          if (multi) begin
            type_nxt = b;
            if (at_end) begin
              done_nxt = 1'b1;
              bad_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_LEN;
            end
          end else if (is_end) begin
            done_nxt = 1'b1;
            if (!at_end) begin
              bad_nxt = 1'b1;
            end
          end
        end
        PH_LEN: begin
          if (len_bad) begin
            done_nxt  = 1'b1;
            bad_nxt   = 1'b1;
            phase_nxt = PH_TYPE;
          end else if (dlen != 6'd0) begin
            left_nxt  = dlen;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
          left_nxt = left_dec;
          if (left_dec == 6'd0) begin
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  assign pos_nxt = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;

  // Record outputs for this byte.
  always_comb begin
    opt_emit = 1'b0;
    if (in_opts) begin
      case (phase_r)
        PH_TYPE: opt_emit = !multi && !is_end;
        PH_LEN:  opt_emit = !len_bad;
        default: opt_emit = 1'b0;
      endcase
    end
  end

  assign fin_bad = (pos_nxt < POS_FIX) || (hlen < 6'(FIXED_HDR_BYTES))
                 || (POS_W'(hlen) > pos_nxt) || bad_nxt;

  always_comb begin
    entry.opt_valid           = opt_emit;
    entry.opt_code            = (phase_r == PH_TYPE) ? b : type_r;
    entry.opt_off             = (phase_r == PH_TYPE) ? 6'd0 : p6 + 6'd1;
    entry.opt_len             = (phase_r == PH_TYPE) ? 6'd0 : dlen;
    entry.fin_valid           = beat.last_byte;
    entry.fin_bad             = fin_bad;
    entry.header_bytes        = hlen;
    entry.protocol            = hdr_v[9];
    entry.fragmented          = |{hdr_v[6][5:0], hdr_v[7]};
    entry.total_length        = {hdr_v[2], hdr_v[3]};
    entry.bytes_received      = 16'(pos_nxt);
    entry.source_address      = {hdr_v[12], hdr_v[13], hdr_v[14], hdr_v[15]};
    entry.destination_address = {hdr_v[16], hdr_v[17], hdr_v[18], hdr_v[19]};
    entry.time_to_live        = hdr_v[8];
    entry.identification      = {hdr_v[4], hdr_v[5]};
  end

  assign push = beat_ok && (opt_emit || beat.last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_TYPE;
      type_r  <= '0;
      left_r  <= '0;
      done_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else if (beat_ok) begin
      if (beat.last_byte) begin
        pos_r   <= '0;
        phase_r <= PH_TYPE;
        type_r  <= '0;
        left_r  <= '0;
        done_r  <= 1'b0;
        bad_r   <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        type_r  <= type_nxt;
        left_r  <= left_nxt;
        done_r  <= done_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

endmodule

### hdl/ihop_queue.sv
`timescale 1ns / 1ps

module ihop_queue
  import ihop_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  output logic     valid,
  output q_entry_t rd_entry,
  input  logic     pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  q_entry_t mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign valid    = count_r != '0;
  assign rd_entry = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  assign wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### hdl/ihop_back.sv
`timescale 1ns / 1ps

module ihop_back
  import ihop_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  logic      opt_sent_r, opt_sent_nxt;

  logic        load_en;
  logic        take_opt;
  logic [15:0] hl16;
  logic [15:0] recv;
  logic [15:0] tot_pay;
  logic [15:0] pay;

  assign load_en  = q_valid && (!out_valid_r || !out_stall);
  assign take_opt = q_entry.opt_valid && !opt_sent_r;
  assign q_pop    = load_en && !(take_opt && q_entry.fin_valid);

  // Payload length: bytes after the header, capped by the total length field.
  assign hl16    = {10'b0, q_entry.header_bytes};
  assign recv    = q_entry.bytes_received - hl16;
  assign tot_pay = q_entry.total_length - hl16;
  assign pay     = (q_entry.total_length != 16'd0 && q_entry.total_length >= hl16
                   && tot_pay < recv) ? tot_pay : recv;

  always_comb begin
    out_data_nxt = '0;
    if (take_opt) begin
      out_data_nxt.record_kind        = KIND_OPTION;
      out_data_nxt.option_type        = q_entry.opt_code;
      out_data_nxt.option_data_offset = q_entry.opt_off;
      out_data_nxt.option_data_length = q_entry.opt_len;
    end else if (q_entry.fin_bad) begin
      out_data_nxt.record_kind = KIND_MALFORMED;
    end else begin
      out_data_nxt.record_kind         = KIND_SUMMARY;
      out_data_nxt.header_bytes        = q_entry.header_bytes;
      out_data_nxt.protocol            = q_entry.protocol;
      out_data_nxt.fragmented          = q_entry.fragmented;
      out_data_nxt.payload_length      = pay;
      out_data_nxt.source_address      = q_entry.source_address;
      out_data_nxt.destination_address = q_entry.destination_address;
      out_data_nxt.time_to_live        = q_entry.time_to_live;
      out_data_nxt.identification      = q_entry.identification;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    opt_sent_nxt  = opt_sent_r;
    if (load_en) begin
      out_valid_nxt = 1'b1;
      opt_sent_nxt  = take_opt && q_entry.fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      opt_sent_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      opt_sent_r  <= opt_sent_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/ipv4_header_option_parser.sv
`timescale 1ns / 1ps

// IPv4 header and option parser. Feed one packet byte per beat on the in_
// channel, starting at the version/IHL byte, with last_byte set on the final
// byte. Every option in the options area but end-of-list comes out as an
// option record as soon as its type (and valid length) byte is seen; the
// final byte adds a header summary or a malformed verdict, after which the
// parser is ready for the next packet with no gap. The input takes one byte
// per cycle while in_stall is low; the output sends one record per cycle
// while out_stall is low, so a byte that yields both an option record and
// the verdict sends them one after the other. A QUEUE_DEPTH-entry queue
// between the byte parser and the record builder absorbs this and any
// out_stall; in_stall rises only while that queue is full. A result passes
// through the queue and then the output register before it shows on out_valid.
// Option records already sent stand even when the packet later turns out
// malformed; a malformed verdict carries only its record kind. Byte counting
// saturates at MAX_PACKET_BYTES.

module ipv4_header_option_parser
  import ihop_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65535,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic     beat_ok;
  logic     push;
  q_entry_t wr_entry;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  // Hold the input while the queue has no room for this beat's entry.
  assign in_stall = q_full;
  assign beat_ok  = in_valid && !in_stall;

  // Front: capture header bytes, walk the options area, build the entry.
  ihop_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_ok(beat_ok),
    .beat   (in_data),
    .push   (push),
    .entry  (wr_entry)
  );

  ihop_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_entry(wr_entry),
    .full    (q_full),
    .valid   (q_valid),
    .rd_entry(q_entry),
    .pop     (q_pop)
  );

  // Back: compute the payload length and advance records out one per beat while out_stall is low.
  ihop_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
